@@ hw/rtl/mjs_pkg.sv @@
`default_nettype none
package mjs_pkg;

  // policy codes
  localparam logic [1:0] POL_FCFS = 2'd0;
  localparam logic [1:0] POL_PRIO = 2'd1;
  localparam logic [1:0] POL_SRT  = 2'd2;
  localparam logic [1:0] POL_RR   = 2'd3;

  // event codes
  localparam logic [1:0] ACT_ARRIVE = 2'd0;
  localparam logic [1:0] ACT_FINISH = 2'd1;
  localparam logic [1:0] ACT_EXPIRE = 2'd2;
  localparam logic [1:0] ACT_NONE   = 2'd3;

  // config register indexes
  localparam logic REG_POLICY = 1'b0;
  localparam logic REG_ACTIVE = 1'b1;

  typedef struct packed {
    logic [15:0] id;
    logic [7:0]  prio;
    logic [15:0] run_len;
    logic [15:0] remaining;
    logic [31:0] arrival;
    logic [31:0] first;
    logic        first_valid;
    logic [31:0] last;
  } job_entry_t;

  localparam int ENTRY_W = $bits(job_entry_t);

  typedef struct packed {
    logic        dispatched;
    logic [2:0]  target_core;
    logic [15:0] next_job;
    logic        queue_overflow;
    logic        stats_valid;
    logic [31:0] wait_time;
    logic [31:0] turn_span;
    logic [31:0] start_lag;
  } result_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHARGE,
    S_ARR_DECIDE,
    S_CORE_RD,
    S_CORE_EVAL,
    S_ENQ,
    S_DONE
  } state_t;

  // true when job a goes ahead of job b
  function automatic logic beats(logic [1:0] pol, job_entry_t a, job_entry_t b);
    logic r;
    unique case (pol)
      POL_FCFS: r = a.arrival < b.arrival;
      POL_PRIO: r = (a.prio != b.prio) ? (a.prio < b.prio) : (a.arrival < b.arrival);
      POL_SRT:  r = (a.remaining != b.remaining) ? (a.remaining < b.remaining)
                                                 : (a.arrival < b.arrival);
      POL_RR:   r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [31:0] sat_sub(logic [31:0] a, logic [31:0] b);
    return (a > b) ? (a - b) : 32'd0;
  endfunction

endpackage
`default_nettype wire

@@ hw/rtl/mjs_ram.sv @@
`default_nettype none
module mjs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

@@ hw/rtl/multicore_job_scheduler.sv @@
// Channel  | Handshake            | Payload
// in       | in_valid / in_stall  | action, job_id, now, run_length, job_priority, core_index
// out      | out_valid / out_stall| dispatched, target_core, next_job, queue_overflow,
//          |                      | stats_valid, wait_time, turn_span, start_lag
// cfg      | cfg_we               | cfg_index, cfg_wdata
// One request at a time. An arrival walks the core table, one core per cycle,
// then, if no core is idle and the queue has room, an ordered insert walks the
// ready queue, one slot per cycle. Finish and expiry read the core and queue head,
// plus the insert when a job is requeued. Both tables sit in single-write RAMs.
// Reset (rst_n low, synchronous) idles all cores and empties the queue.
// in_stall is high while a request is in work; a stalled result waits in the
// output register and the next request is taken meanwhile.
`default_nettype none
module multicore_job_scheduler #(
  parameter int NUM_CORES   = 8,
  parameter int QUEUE_DEPTH = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_action,
  input  wire logic [15:0] in_job_id,
  input  wire logic [31:0] in_now,
  input  wire logic [15:0] in_run_length,
  input  wire logic [7:0]  in_job_priority,
  input  wire logic [2:0]  in_core_index,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_dispatched,
  output logic [2:0]       out_target_core,
  output logic [15:0]      out_next_job,
  output logic             out_queue_overflow,
  output logic             out_stats_valid,
  output logic [31:0]      out_wait_time,
  output logic [31:0]      out_turn_span,
  output logic [31:0]      out_start_lag
);

  localparam int CW  = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int NW  = $clog2(NUM_CORES + 1);
  localparam int XW  = (NW > 4) ? NW : 4;
  localparam int CIW = (NW > 3) ? NW : 3;
  localparam int QW  = $clog2(QUEUE_DEPTH);
  localparam int CNW = $clog2(QUEUE_DEPTH + 1);

  mjs_pkg::state_t state_r, state_nxt;

  logic [1:0]  policy_r, policy_nxt;
  logic [3:0]  active_r, active_nxt;
  logic [1:0]  act_r, act_nxt;
  logic [15:0] id_r, id_nxt;
  logic [31:0] now_r, now_nxt;
  logic [15:0] rlen_r, rlen_nxt;
  logic [7:0]  prio_r, prio_nxt;
  logic [CW-1:0] ci_r, ci_nxt;

  logic [NUM_CORES-1:0] busy_r, busy_nxt;
  logic [QW-1:0]  head_r, head_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;

  logic [NW-1:0] idx_r, idx_nxt;
  logic          pv_r, pv_nxt;
  logic [CW-1:0] pidx_r, pidx_nxt;
  logic          idle_found_r, idle_found_nxt;
  logic [CW-1:0] idle_core_r, idle_core_nxt;
  logic          pre_found_r, pre_found_nxt;
  logic [CW-1:0] pre_core_r, pre_core_nxt;
  mjs_pkg::job_entry_t worst_r, worst_nxt;

  logic [CNW-1:0] kiss_r, kiss_nxt;
  logic [CNW-1:0] pk_r, pk_nxt;
  logic           ptail_r, ptail_nxt;
  logic           ins_done_r, ins_done_nxt;
  mjs_pkg::job_entry_t enq_r, enq_nxt;
  mjs_pkg::job_entry_t carry_r, carry_nxt;

  mjs_pkg::result_t res_r, res_nxt;
  mjs_pkg::result_t out_r, out_nxt;
  logic out_valid_r, out_valid_nxt;

  // memory ports
  logic          core_we;
  logic [CW-1:0] core_waddr, core_raddr;
  mjs_pkg::job_entry_t core_wdata, cd;
  logic [mjs_pkg::ENTRY_W-1:0] core_rdata;
  logic          q_we;
  logic [QW-1:0] q_waddr, q_raddr;
  mjs_pkg::job_entry_t q_wdata, qd;
  logic [mjs_pkg::ENTRY_W-1:0] q_rdata;

  mjs_ram #(.WIDTH(mjs_pkg::ENTRY_W), .DEPTH(NUM_CORES)) u_core_ram (
    .clk(clk), .we(core_we), .waddr(core_waddr), .wdata(core_wdata),
    .raddr(core_raddr), .rdata(core_rdata)
  );

  mjs_ram #(.WIDTH(mjs_pkg::ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_queue_ram (
    .clk(clk), .we(q_we), .waddr(q_waddr), .wdata(q_wdata),
    .raddr(q_raddr), .rdata(q_rdata)
  );

  assign cd = core_rdata;
  assign qd = q_rdata;

  // logical queue slot to RAM address
  function automatic logic [QW-1:0] qaddr(logic [QW-1:0] h, logic [CNW-1:0] k);
    logic [QW+1:0] s;
    s = (QW+2)'(h) + (QW+2)'(k);
    if (s >= (QW+2)'(QUEUE_DEPTH)) begin
      s = s - (QW+2)'(QUEUE_DEPTH);
    end
    return s[QW-1:0];
  endfunction

  logic in_acc;
  logic [XW-1:0] act_x;
  logic [NW-1:0] n_eff;
  logic [CIW-1:0] ci_x;
  logic ci_ok;
  logic q_full, q_any;
  logic ci_busy;
  logic scan_end, charge_end;
  logic expire_swap;
  mjs_pkg::job_entry_t new_rec, charged, head_rec;
  logic [QW-1:0] head_inc;

  assign in_acc = in_valid && !in_stall;
  assign in_stall = (state_r != mjs_pkg::S_IDLE);

  assign act_x = XW'(active_r);
  always_comb begin
    if (act_x == '0) begin
      n_eff = NW'(1);
    end else if (act_x > XW'(NUM_CORES)) begin
      n_eff = NW'(NUM_CORES);
    end else begin
      n_eff = act_x[NW-1:0];
    end
  end

  assign ci_x  = CIW'(in_core_index);
  assign ci_ok = ci_x < CIW'(NUM_CORES);
  assign q_full = (cnt_r == CNW'(QUEUE_DEPTH));
  assign q_any  = (cnt_r != '0);
  assign ci_busy = busy_r[ci_r];
  assign charge_end = !pv_r && (idx_r >= n_eff);
  assign scan_end = !pv_r && (kiss_r > cnt_r);
  assign head_inc = (head_r == QW'(QUEUE_DEPTH - 1)) ? '0 : head_r + 1'b1;
  assign expire_swap = (act_r == mjs_pkg::ACT_EXPIRE) && ci_busy && q_any &&
                       !mjs_pkg::beats(policy_r, cd, qd);

  always_comb begin
    new_rec = '0;
    new_rec.id          = id_r;
    new_rec.prio        = prio_r;
    new_rec.run_len     = rlen_r;
    new_rec.remaining   = rlen_r;
    new_rec.arrival     = now_r;
    new_rec.first       = now_r;
    new_rec.first_valid = 1'b1;
    new_rec.last        = now_r;

    charged = cd;
    charged.remaining = 16'(mjs_pkg::sat_sub(32'(cd.remaining), now_r - cd.last));
    charged.last = now_r;

    head_rec = qd;
    if (!qd.first_valid) begin
      head_rec.first = now_r;
    end
    head_rec.first_valid = 1'b1;
    head_rec.last = now_r;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      mjs_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_action == mjs_pkg::ACT_ARRIVE) begin
            state_nxt = mjs_pkg::S_CHARGE;
          end else if (in_action != mjs_pkg::ACT_NONE && ci_ok) begin
            state_nxt = mjs_pkg::S_CORE_RD;
          end else begin
            state_nxt = mjs_pkg::S_DONE;
          end
        end
      end
      mjs_pkg::S_CHARGE: begin
        if (charge_end) begin
          state_nxt = mjs_pkg::S_ARR_DECIDE;
        end
      end
      mjs_pkg::S_ARR_DECIDE: begin
        if (!idle_found_r && !q_full) begin
          state_nxt = mjs_pkg::S_ENQ;
        end else begin
          state_nxt = mjs_pkg::S_DONE;
        end
      end
      mjs_pkg::S_CORE_RD: state_nxt = mjs_pkg::S_CORE_EVAL;
      mjs_pkg::S_CORE_EVAL: begin
        state_nxt = expire_swap ? mjs_pkg::S_ENQ : mjs_pkg::S_DONE;
      end
      mjs_pkg::S_ENQ: begin
        if (scan_end) begin
          state_nxt = mjs_pkg::S_DONE;
        end
      end
      mjs_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = mjs_pkg::S_IDLE;
        end
      end
    endcase
  end

  // datapath and memory ports
  always_comb begin
    policy_nxt = policy_r;
    active_nxt = active_r;
    act_nxt = act_r;
    id_nxt = id_r;
    now_nxt = now_r;
    rlen_nxt = rlen_r;
    prio_nxt = prio_r;
    ci_nxt = ci_r;
    busy_nxt = busy_r;
    head_nxt = head_r;
    cnt_nxt = cnt_r;
    idx_nxt = idx_r;
    pv_nxt = pv_r;
    pidx_nxt = pidx_r;
    idle_found_nxt = idle_found_r;
    idle_core_nxt = idle_core_r;
    pre_found_nxt = pre_found_r;
    pre_core_nxt = pre_core_r;
    worst_nxt = worst_r;
    kiss_nxt = kiss_r;
    pk_nxt = pk_r;
    ptail_nxt = ptail_r;
    ins_done_nxt = ins_done_r;
    enq_nxt = enq_r;
    carry_nxt = carry_r;
    res_nxt = res_r;
    out_nxt = out_r;
    out_valid_nxt = out_valid_r;

    core_we = 1'b0;
    core_waddr = ci_r;
    core_wdata = new_rec;
    core_raddr = ci_r;
    q_we = 1'b0;
    q_waddr = qaddr(head_r, pk_r);
    q_wdata = enq_r;
    q_raddr = head_r;

    if (cfg_we) begin
      if (cfg_index == mjs_pkg::REG_POLICY) begin
        policy_nxt = cfg_wdata[1:0];
      end else begin
        active_nxt = cfg_wdata;
      end
    end

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      mjs_pkg::S_IDLE: begin
        if (in_acc) begin
          act_nxt  = in_action;
          id_nxt   = in_job_id;
          now_nxt  = in_now;
          rlen_nxt = in_run_length;
          prio_nxt = in_job_priority;
          ci_nxt   = ci_x[CW-1:0];
          res_nxt  = '0;
          idx_nxt  = '0;
          pv_nxt   = 1'b0;
          idle_found_nxt = 1'b0;
          pre_found_nxt  = 1'b0;
        end
      end
      mjs_pkg::S_CHARGE: begin
        // read core i+1 while charging core i
        if (idx_r < n_eff) begin
          core_raddr = idx_r[CW-1:0];
          pv_nxt = 1'b1;
          pidx_nxt = idx_r[CW-1:0];
          idx_nxt = idx_r + 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (busy_r[pidx_r]) begin
            core_we = 1'b1;
            core_waddr = pidx_r;
            core_wdata = charged;
            if (!pre_found_r) begin
              if (mjs_pkg::beats(policy_r, new_rec, charged)) begin
                pre_found_nxt = 1'b1;
                pre_core_nxt = pidx_r;
                worst_nxt = charged;
              end
            end else if (mjs_pkg::beats(policy_r, worst_r, charged)) begin
              pre_core_nxt = pidx_r;
              worst_nxt = charged;
            end
          end else if (!idle_found_r) begin
            idle_found_nxt = 1'b1;
            idle_core_nxt = pidx_r;
          end
        end
      end
      mjs_pkg::S_ARR_DECIDE: begin
        kiss_nxt = '0;
        pv_nxt = 1'b0;
        ins_done_nxt = 1'b0;
        if (idle_found_r) begin
          core_we = 1'b1;
          core_waddr = idle_core_r;
          core_wdata = new_rec;
          busy_nxt[idle_core_r] = 1'b1;
          res_nxt.dispatched = 1'b1;
          res_nxt.target_core = 3'(idle_core_r);
          res_nxt.next_job = id_r;
        end else if (q_full) begin
          res_nxt.queue_overflow = 1'b1;
        end else if (policy_r == mjs_pkg::POL_SRT && pre_found_r) begin
          core_we = 1'b1;
          core_waddr = pre_core_r;
          core_wdata = new_rec;
          enq_nxt = worst_r;
          // preempted at the instant it started: it never really ran
          if (worst_r.first_valid && worst_r.first == now_r) begin
            enq_nxt.first_valid = 1'b0;
          end
          res_nxt.dispatched = 1'b1;
          res_nxt.target_core = 3'(pre_core_r);
          res_nxt.next_job = id_r;
        end else begin
          enq_nxt = new_rec;
          enq_nxt.first_valid = 1'b0;
          enq_nxt.first = '0;
        end
      end
      mjs_pkg::S_CORE_RD: begin
        core_raddr = ci_r;
        q_raddr = head_r;
      end
      mjs_pkg::S_CORE_EVAL: begin
        kiss_nxt = '0;
        pv_nxt = 1'b0;
        ins_done_nxt = 1'b0;
        enq_nxt = cd;
        core_waddr = ci_r;
        if (act_r == mjs_pkg::ACT_FINISH) begin
          if (ci_busy) begin
            res_nxt.stats_valid = 1'b1;
            res_nxt.turn_span = mjs_pkg::sat_sub(now_r, cd.arrival);
            res_nxt.wait_time = mjs_pkg::sat_sub(mjs_pkg::sat_sub(now_r, cd.arrival),
                                                 32'(cd.run_len));
            res_nxt.start_lag = mjs_pkg::sat_sub(cd.first, cd.arrival);
          end
          busy_nxt[ci_r] = q_any;
        end
        if ((act_r == mjs_pkg::ACT_EXPIRE) && ci_busy && !expire_swap) begin
          core_we = 1'b1;
          core_wdata = cd;
          core_wdata.last = now_r;
          res_nxt.dispatched = 1'b1;
          res_nxt.target_core = 3'(ci_r);
          res_nxt.next_job = cd.id;
        end else if (q_any) begin
          // head of queue goes onto the core
          core_we = 1'b1;
          core_wdata = head_rec;
          busy_nxt[ci_r] = 1'b1;
          head_nxt = head_inc;
          cnt_nxt = cnt_r - 1'b1;
          res_nxt.dispatched = 1'b1;
          res_nxt.target_core = 3'(ci_r);
          res_nxt.next_job = qd.id;
        end
      end
      mjs_pkg::S_ENQ: begin
        // forward pass: find the slot, then carry each entry up by one
        if (kiss_r <= cnt_r) begin
          q_raddr = qaddr(head_r, kiss_r);
          pv_nxt = 1'b1;
          pk_nxt = kiss_r;
          ptail_nxt = (kiss_r == cnt_r);
          kiss_nxt = kiss_r + 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r) begin
          if (!ins_done_r) begin
            if (ptail_r || mjs_pkg::beats(policy_r, enq_r, qd)) begin
              q_we = 1'b1;
              q_wdata = enq_r;
              ins_done_nxt = 1'b1;
              carry_nxt = qd;
            end
          end else begin
            q_we = 1'b1;
            q_wdata = carry_r;
            carry_nxt = qd;
          end
        end
        if (scan_end) begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      mjs_pkg::S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_nxt = res_r;
          out_valid_nxt = 1'b1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mjs_pkg::S_IDLE;
      policy_r <= mjs_pkg::POL_FCFS;
      active_r <= 4'd1;
      busy_r <= '0;
      head_r <= '0;
      cnt_r <= '0;
      out_valid_r <= 1'b0;
      pv_r <= 1'b0;
      idx_r <= '0;
      kiss_r <= '0;
      ins_done_r <= 1'b0;
      idle_found_r <= 1'b0;
      pre_found_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      policy_r <= policy_nxt;
      active_r <= active_nxt;
      busy_r <= busy_nxt;
      head_r <= head_nxt;
      cnt_r <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      pv_r <= pv_nxt;
      idx_r <= idx_nxt;
      kiss_r <= kiss_nxt;
      ins_done_r <= ins_done_nxt;
      idle_found_r <= idle_found_nxt;
      pre_found_r <= pre_found_nxt;
    end
  end

  always_ff @(posedge clk) begin
    act_r <= act_nxt;
    id_r <= id_nxt;
    now_r <= now_nxt;
    rlen_r <= rlen_nxt;
    prio_r <= prio_nxt;
    ci_r <= ci_nxt;
    pidx_r <= pidx_nxt;
    idle_core_r <= idle_core_nxt;
    pre_core_r <= pre_core_nxt;
    worst_r <= worst_nxt;
    pk_r <= pk_nxt;
    ptail_r <= ptail_nxt;
    enq_r <= enq_nxt;
    carry_r <= carry_nxt;
    res_r <= res_nxt;
    out_r <= out_nxt;
  end

  assign out_valid          = out_valid_r;
  assign out_dispatched     = out_r.dispatched;
  assign out_target_core    = out_r.target_core;
  assign out_next_job       = out_r.next_job;
  assign out_queue_overflow = out_r.queue_overflow;
  assign out_stats_valid    = out_r.stats_valid;
  assign out_wait_time      = out_r.wait_time;
  assign out_turn_span      = out_r.turn_span;
  assign out_start_lag      = out_r.start_lag;

endmodule
`default_nettype wire

@@ hw/rtl/mjs_checker.sv @@
`default_nettype none
module mjs_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_valid,
  input wire logic        in_stall,
  input wire logic        out_valid,
  input wire logic        out_stall,
  input wire logic        out_dispatched,
  input wire logic [2:0]  out_target_core,
  input wire logic [15:0] out_next_job,
  input wire logic        out_queue_overflow,
  input wire logic        out_stats_valid,
  input wire logic [31:0] out_wait_time,
  input wire logic [31:0] out_turn_span,
  input wire logic [31:0] out_start_lag
);

  // a taken request holds off the next one
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request accepted back to back");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result dropped");

  a_no_dispatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_dispatched |-> out_target_core == 3'd0 && out_next_job == 16'd0)
    else $error("core fields set without dispatch");

  a_overflow_alone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_queue_overflow |-> !out_dispatched && !out_stats_valid)
    else $error("dropped arrival also dispatched");

  a_stats_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_stats_valid |->
      out_wait_time == 32'd0 && out_turn_span == 32'd0 && out_start_lag == 32'd0)
    else $error("timing figures without finish");

endmodule

bind multicore_job_scheduler mjs_checker u_mjs_checker (.*);
`default_nettype wire
